// ===== src/dis_pkg.sv =====
`timescale 1ns / 1ps

package dis_pkg;

  // number of cells in the sorting row
  localparam int ENTRIES = 256;

  localparam int KEY_W    = 17;
  localparam int TAG_W    = 10;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 9;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } record_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic    load;
    logic    pop;
    record_t ins;
  } cell_ctrl_t;

endpackage

// ===== src/dis_if.sv =====
`timescale 1ns / 1ps

interface dis_req_if import dis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;

  modport source (output valid, output mode, output key, output tag, input ready);
  modport sink   (input valid, input mode, input key, input tag, output ready);
endinterface

interface dis_rsp_if import dis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [TAG_W-1:0]    tag_out;
  logic                last;
  logic [HELD_W-1:0]   held_count;

  modport source (output valid, output status, output key_out, output tag_out,
                  output last, output held_count, input ready);
  modport sink   (input valid, input status, input key_out, input tag_out,
                  input last, input held_count, output ready);
endinterface

// ===== src/dis_cell.sv =====
`timescale 1ns / 1ps

module dis_cell import dis_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  record_t    prev_rec,
  input  logic       prev_keeps,
  input  record_t    next_rec,
  input  logic       occupied,
  output record_t    rec,
  output logic       keeps
);

  // held record stays put when it outranks the incoming key
  assign keeps = occupied && (rec.key > ctrl.ins.key);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rec <= next_rec;
    end else if (ctrl.load && !keeps) begin
      rec <= prev_keeps ? ctrl.ins : prev_rec;
    end
  end

endmodule

// ===== src/descending_insertion_sorter_unit.sv =====
`timescale 1ns / 1ps
// a request's result is registered and valid in the cycle after the request is taken
// throughput: one request per cycle while result.ready is high; a row of compare
//   cells inserts or pops in one step, all comparing the broadcast key in parallel
// reset (rst, synchronous): store emptied (count zero), result register empty
// the record storage itself has no reset; slots beyond the count are ignored

module descending_insertion_sorter_unit import dis_pkg::*; (
  input logic       clk,
  input logic       rst,
  dis_req_if.sink   request,
  dis_rsp_if.source result
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             do_load;
  logic             do_pop;
  cell_ctrl_t       ctrl;

  record_t          recs  [ENTRIES];
  logic             keeps [ENTRIES];
  logic             occ   [ENTRIES];

  // result register
  logic              rsp_valid;
  status_t           rsp_status;
  status_t           rsp_status_next;
  record_t           rsp_rec;
  record_t           rsp_rec_next;
  logic              rsp_last;
  logic              rsp_last_next;
  logic [CNT_W-1:0]  rsp_count;

  // a new request is taken whenever the result slot is free or draining
  assign request.ready = !rsp_valid || result.ready;
  assign accept        = request.valid && request.ready;

  assign full    = (count == CNT_W'(ENTRIES));
  assign empty   = (count == '0);
  assign do_load = accept && (request.mode == MODE_LOAD) && !full;
  assign do_pop  = accept && (request.mode == MODE_POP) && !empty;

  assign ctrl.load    = do_load;
  assign ctrl.pop     = do_pop;
  assign ctrl.ins.key = request.key;
  assign ctrl.ins.tag = request.tag;

  // the cell row: head cell holds the largest key
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign occ[g] = (count > CNT_W'(g));

    if (g == 0) begin : g_head
      if (ENTRIES > 1) begin : g_more
        dis_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .prev_rec   ('0),
          .prev_keeps (1'b1),
          .next_rec   (recs[g+1]),
          .occupied   (occ[g]),
          .rec        (recs[g]),
          .keeps      (keeps[g])
        );
      end else begin : g_one
        dis_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .prev_rec   ('0),
          .prev_keeps (1'b1),
          .next_rec   ('0),
          .occupied   (occ[g]),
          .rec        (recs[g]),
          .keeps      (keeps[g])
        );
      end
    end else if (g == ENTRIES - 1) begin : g_tail
      dis_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .prev_rec   (recs[g-1]),
        .prev_keeps (keeps[g-1]),
        .next_rec   ('0),
        .occupied   (occ[g]),
        .rec        (recs[g]),
        .keeps      (keeps[g])
      );
    end else begin : g_mid
      dis_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .prev_rec   (recs[g-1]),
        .prev_keeps (keeps[g-1]),
        .next_rec   (recs[g+1]),
        .occupied   (occ[g]),
        .rec        (recs[g]),
        .keeps      (keeps[g])
      );
    end
  end

  // result fields for the request being taken
  always_comb begin
    count_next      = count;
    rsp_status_next = STATUS_OK;
    rsp_rec_next    = '0;
    rsp_last_next   = 1'b0;
    if (request.mode == MODE_LOAD) begin
      if (full) begin
        rsp_status_next = STATUS_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        rsp_status_next = STATUS_EMPTY;
      end else begin
        count_next    = count - CNT_W'(1);
        rsp_rec_next  = recs[0];
        rsp_last_next = (count == CNT_W'(1));
      end
    end
  end

  // store occupancy and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (result.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= rsp_status_next;
      rsp_rec    <= rsp_rec_next;
      rsp_last   <= rsp_last_next;
      rsp_count  <= count_next;
    end
  end

  assign result.valid      = rsp_valid;
  assign result.status     = rsp_status;
  assign result.key_out    = rsp_rec.key;
  assign result.tag_out    = rsp_rec.tag;
  assign result.last       = rsp_last;
  assign result.held_count = HELD_W'(rsp_count);

endmodule
